@@ rtl/core/fagc_pkg.sv @@
package fagc_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 15;
    localparam int REG_W    = 15;
    localparam int ADDR_W   = 3;
    localparam int MUL_W    = 16;
    localparam int PROD_W   = 2 * MUL_W;

    // Fraction bits of the gain and of the rate coefficients
    localparam int GAIN_FRAC = 11;
    localparam int RATE_FRAC = 15;

    // Unity gain in Q4.11, also the lower clamp
    localparam logic [GAIN_W-1:0] UNITY_GAIN = 15'd2048;

    // Register reset values
    localparam logic [REG_W-1:0] TARGET_RST    = 15'd16384;
    localparam logic [REG_W-1:0] GAIN_LIM_RST  = 15'd2048;
    localparam logic [REG_W-1:0] ATTACK_RST    = 15'd327;
    localparam logic [REG_W-1:0] DECAY_RST     = 15'd32;
    localparam logic [REG_W-1:0] NOISE_THR_RST = 15'd655;

    // Register indexes on the configuration port
    localparam logic [ADDR_W-1:0] REG_TARGET    = 3'd0;
    localparam logic [ADDR_W-1:0] REG_GAIN_LIM  = 3'd1;
    localparam logic [ADDR_W-1:0] REG_ATTACK    = 3'd2;
    localparam logic [ADDR_W-1:0] REG_DECAY     = 3'd3;
    localparam logic [ADDR_W-1:0] REG_NOISE_THR = 3'd4;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } fagc_state_t;

    // Sequencer controls to the datapath
    typedef struct packed {
        logic load_front;  // first pass: sample times gain
        logic sel_upd;     // second pass: error times rate
        logic commit;      // update gain and load output word
    } fagc_ctl_t;

endpackage

@@ rtl/core/fixed_point_agc.sv @@
// Automatic gain control for Q15 samples with a Q4.11 gain. Each input word
// is multiplied by the stored gain (floor shift by 11, saturated to 16 bits);
// when the absolute input exceeds noise_threshold the gain moves by
// (target - |out|) times attack_rate (negative error) or decay_rate
// (positive error), floor-shifted by 15. Either way the gain is clamped below at 2048 and
// above at the gain limit. One multiplier is shared by the sample product and
// the gain-update product, and the next sample needs the updated gain, so no
// sample is taken during the update pass. in_ready is high in the idle state;
// the result sits in an output register, so a new sample is taken while it waits,
// and the update pass stretches only while that register is full and unread.
// Configuration writes are always accepted (cfg_ready is high); indexes past
// noise_threshold are ignored. Write registers only while the block is idle.
module fixed_point_agc (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [fagc_pkg::SAMPLE_W-1:0]  in_sample,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [fagc_pkg::SAMPLE_W-1:0]  out_sample,
    output logic        [fagc_pkg::GAIN_W-1:0]    gain_now,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic        [fagc_pkg::ADDR_W-1:0]    cfg_addr,
    input  logic        [fagc_pkg::REG_W-1:0]     cfg_data
);
    import fagc_pkg::*;

    function automatic logic [REG_W-1:0] abs_sat(input logic signed [SAMPLE_W-1:0] v);
        logic signed [SAMPLE_W-1:0] neg;
        neg = -v;
        if (v == {1'b1, {(SAMPLE_W-1){1'b0}}})
            abs_sat = {REG_W{1'b1}};
        else if (v[SAMPLE_W-1])
            abs_sat = neg[REG_W-1:0];
        else
            abs_sat = v[REG_W-1:0];
    endfunction

    logic [REG_W-1:0]  target_reg;
    logic [REG_W-1:0]  gain_lim_reg;
    logic [REG_W-1:0]  attack_reg;
    logic [REG_W-1:0]  decay_reg;
    logic [REG_W-1:0]  noise_thr_reg;
    logic [GAIN_W-1:0] gain_reg;

    logic signed [SAMPLE_W-1:0] y_reg;
    logic [REG_W-1:0]           abs_out_reg;
    logic                       gate_reg;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic [GAIN_W-1:0]          gain_now_reg;

    fagc_ctl_t                  ctl;
    logic                       out_hold;
    logic signed [PROD_W-1:0]   prod;
    logic signed [MUL_W-1:0]    err;
    logic [REG_W-1:0]           rate;

    logic signed [PROD_W-GAIN_FRAC-2:0] y_full;
    logic signed [SAMPLE_W-1:0]         y_sat;
    logic signed [PROD_W-RATE_FRAC-1:0] delta;
    logic signed [GAIN_W+2:0]           g_sum;
    logic signed [GAIN_W+2:0]           g_low;
    logic [GAIN_W-1:0]                  gain_next;

    assign cfg_ready = 1'b1;
    assign out_hold  = out_valid_reg && !out_ready;

    // Sequencer
    fagc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_hold (out_hold),
        .in_ready (in_ready),
        .ctl      (ctl)
    );

    // Error and rate select for the update pass
    always_comb
    begin
        err  = signed'({1'b0, target_reg}) - signed'({1'b0, abs_out_reg});
        rate = err[MUL_W-1] ? attack_reg : decay_reg;
    end

    // Shared multiplier
    fagc_mul u_mul (
        .sel_upd (ctl.sel_upd),
        .sample  (in_sample),
        .gain    (gain_reg),
        .err     (err),
        .rate    (rate),
        .prod    (prod)
    );

    // First pass: floor shift by 11 and saturate
    always_comb
    begin
        y_full = prod[PROD_W-2:GAIN_FRAC];
        if (y_full > 20'sd32767)
            y_sat = 16'sh7FFF;
        else if (y_full < -20'sd32768)
            y_sat = 16'sh8000;
        else
            y_sat = y_full[SAMPLE_W-1:0];
    end

    // Second pass: floor shift by 15, add, clamp low then high
    always_comb
    begin
        delta = prod[PROD_W-1:RATE_FRAC];
        if (gate_reg)
            g_sum = signed'({3'b000, gain_reg}) + 18'(delta);
        else
            g_sum = signed'({3'b000, gain_reg});
        if (g_sum < signed'({3'b000, UNITY_GAIN}))
            g_low = signed'({3'b000, UNITY_GAIN});
        else
            g_low = g_sum;
        if (g_low > signed'({3'b000, gain_lim_reg}))
            gain_next = gain_lim_reg;
        else
            gain_next = g_low[GAIN_W-1:0];
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= TARGET_RST;
            gain_lim_reg  <= GAIN_LIM_RST;
            attack_reg    <= ATTACK_RST;
            decay_reg     <= DECAY_RST;
            noise_thr_reg <= NOISE_THR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                REG_TARGET:    target_reg    <= cfg_data;
                REG_GAIN_LIM:  gain_lim_reg  <= cfg_data;
                REG_ATTACK:    attack_reg    <= cfg_data;
                REG_DECAY:     decay_reg     <= cfg_data;
                REG_NOISE_THR: noise_thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Gain state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= UNITY_GAIN;
        else if (ctl.commit)
            gain_reg <= gain_next;
    end

    // First-pass results
    always_ff @(posedge clk)
    begin
        if (ctl.load_front)
        begin
            y_reg       <= y_sat;
            abs_out_reg <= abs_sat(y_sat);
            gate_reg    <= abs_sat(in_sample) > noise_thr_reg;
        end
    end

    // Output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.commit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output word payload
    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            out_sample_reg <= y_reg;
            gain_now_reg   <= gain_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign gain_now   = gain_now_reg;

    // A committed word is presented next cycle
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> out_valid)
        else $error("committed word not presented");

    // An accepted sample leaves the block busy for its update pass
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!in_ready && ctl.sel_upd))
        else $error("input taken during update pass");

    // Commit never overwrites a word still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten");

    // Reported gain never exceeds the upper clamp
    a_gain_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> (gain_now <= gain_lim_reg))
        else $error("gain above limit");

endmodule

@@ rtl/core/fagc_mul.sv @@
module fagc_mul (
    input  logic                                  sel_upd,
    input  logic signed [fagc_pkg::SAMPLE_W-1:0]  sample,
    input  logic        [fagc_pkg::GAIN_W-1:0]    gain,
    input  logic signed [fagc_pkg::MUL_W-1:0]     err,
    input  logic        [fagc_pkg::REG_W-1:0]     rate,
    output logic signed [fagc_pkg::PROD_W-1:0]    prod
);
    import fagc_pkg::*;

    logic signed [MUL_W-1:0] op_a;
    logic signed [MUL_W-1:0] op_b;

    // Operand select: sample x gain, then error x rate
    always_comb
    begin
        if (sel_upd)
        begin
            op_a = err;
            op_b = signed'({1'b0, rate});
        end
        else
        begin
            op_a = sample;
            op_b = signed'({1'b0, gain});
        end
    end

    // Shared signed multiplier
    assign prod = op_a * op_b;

endmodule

@@ rtl/core/fagc_ctrl.sv @@
module fagc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  out_hold,
    output logic                  in_ready,
    output fagc_pkg::fagc_ctl_t   ctl
);
    import fagc_pkg::*;

    fagc_state_t state_reg;
    fagc_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!out_hold)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready       = 1'b0;
        ctl.load_front = 1'b0;
        ctl.sel_upd    = 1'b0;
        ctl.commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                ctl.load_front = in_valid;
            end
            ST_UPDATE:
            begin
                ctl.sel_upd = 1'b1;
                ctl.commit  = !out_hold;
            end
            default: ;
        endcase
    end

endmodule

@@ test/testbench.sv @@
module testbench;
    import fagc_pkg::*;

    // Indexes past the last register; writes to them must be dropped
    localparam logic [ADDR_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [ADDR_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int N_DIRECTED = 40;
    localparam int N_PHASES   = 10;
    localparam int PHASE_LEN  = 63;

    typedef enum logic {
        ROW_WRITE,
        ROW_WORD
    } row_kind_t;

    // One row of the directed table: a register write or a sample word.
    // Sample rows with has_exp set carry a hand-computed result.
    typedef struct {
        row_kind_t         kind;
        logic [ADDR_W-1:0] addr;
        int                value;
        bit                has_exp;
        int                exp_smp;
        int                exp_gain;
    } stim_row_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] smp;
        logic        [GAIN_W-1:0]   gain;
    } agc_word_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [SAMPLE_W-1:0] out_sample;
    logic        [GAIN_W-1:0]   gain_now;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic        [ADDR_W-1:0]   cfg_addr;
    logic        [REG_W-1:0]    cfg_data;

    // Shadow copy of the block's registers and gain
    logic [REG_W-1:0] target_lvl;
    logic [REG_W-1:0] gain_lim;
    logic [REG_W-1:0] attack;
    logic [REG_W-1:0] decay;
    logic [REG_W-1:0] noise_thr;
    longint           gain_state;

    agc_word_t  pending_words[$];
    stim_row_t  directed_rows [0:N_DIRECTED-1];
    int         mismatch_count;
    bit         steady;
    int         ready_hold;

    fixed_point_agc u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_sample  (in_sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_sample (out_sample),
        .gain_now   (gain_now),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Gain the sample, then move and clamp the gain
    function automatic void agc_apply(input logic signed [SAMPLE_W-1:0] smp,
                                      output agc_word_t res);
        longint x;
        longint y;
        longint mag_in;
        longint mag_out;
        longint err;
        longint rate;
        longint g;
        x = smp;
        y = (x * gain_state) >>> GAIN_FRAC;
        if (y > 32767)
            y = 32767;
        if (y < -32768)
            y = -32768;
        mag_in  = (x == -32768) ? 32767 : ((x < 0) ? -x : x);
        mag_out = (y == -32768) ? 32767 : ((y < 0) ? -y : y);
        g = gain_state;
        if (mag_in > longint'(noise_thr))
        begin
            err  = longint'(target_lvl) - mag_out;
            rate = (err < 0) ? longint'(attack) : longint'(decay);
            g    = g + ((err * rate) >>> RATE_FRAC);
        end
        // lower clamp first, so a limit below unity wins
        if (g < longint'(UNITY_GAIN))
            g = UNITY_GAIN;
        if (g > longint'(gain_lim))
            g = gain_lim;
        gain_state = g;
        res.smp  = y[SAMPLE_W-1:0];
        res.gain = g[GAIN_W-1:0];
    endfunction

    // Sender gap: mostly none, sometimes short, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(15, 50);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            case ($urandom_range(0, 4))
                0: v = 32767;
                1: v = -32768;
                2: v = 0;
                3: v = -1;
                default: v = 1;
            endcase
        end
        else if (r < 30)
        begin
            // right around the noise gate
            v = int'(noise_thr) + $urandom_range(0, 4) - 2;
            if (v > 32767)
                v = 32767;
            if ($urandom_range(0, 1))
                v = -v;
        end
        else if (r < 60)
            v = $urandom_range(0, 4095) - 2048;
        else
            v = $signed(16'($urandom));
        return 16'(v);
    endfunction

    // Random register value with the extremes weighted in
    function automatic logic [REG_W-1:0] random_reg(input int lo_span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return 15'd32767;
        if (r < 60)
            return 15'($urandom_range(0, lo_span));
        return 15'($urandom);
    endfunction

    // Drive one sample word and record its expected result on acceptance
    task automatic send_word(input logic signed [SAMPLE_W-1:0] smp, input bit has_exp,
                             input int exp_smp, input int exp_gain);
        int gap;
        agc_word_t w;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_sample <= smp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        agc_apply(smp, w);
        if (has_exp)
        begin
            w.smp  = 16'(exp_smp);
            w.gain = 15'(exp_gain);
        end
        pending_words.push_back(w);
        @(negedge clk);
    endtask

    // Hold off the sender until every result is back and the block settles
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [REG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (addr)
            REG_TARGET:    target_lvl = data;
            REG_GAIN_LIM:  gain_lim   = data;
            REG_ATTACK:    attack     = data;
            REG_DECAY:     decay      = data;
            REG_NOISE_THR: noise_thr  = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Receiver stall pattern
    always @(negedge clk)
    begin
        if (steady)
            out_ready <= 1'b1;
        else if (ready_hold > 0)
            ready_hold--;
        else
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10:
                begin
                    out_ready  <= 1'b1;
                    ready_hold = $urandom_range(0, 8);
                end
                11, 12, 13, 14, 15, 16, 17:
                begin
                    out_ready  <= 1'b0;
                    ready_hold = $urandom_range(0, 2);
                end
                18:
                begin
                    out_ready  <= 1'b0;
                    ready_hold = $urandom_range(4, 12);
                end
                default:
                begin
                    out_ready  <= 1'b0;
                    ready_hold = $urandom_range(20, 60);
                end
            endcase
        end
    end

    // Compare each result word against the oldest expectation
    always @(posedge clk)
    begin : check_word
        agc_word_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t unexpected word: out_sample %0d gain_now %0d",
                         $time, out_sample, gain_now);
                mismatch_count++;
            end
            else
            begin
                w = pending_words.pop_front();
                if (out_sample !== w.smp)
                begin
                    $display("%0t out_sample mismatch: expected %0d, got %0d",
                             $time, w.smp, out_sample);
                    mismatch_count++;
                end
                if (gain_now !== w.gain)
                begin
                    $display("%0t gain_now mismatch: expected %0d, got %0d",
                             $time, w.gain, gain_now);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_sample  = '0;
        out_ready  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_addr   = '0;
        cfg_data   = '0;
        steady     = 1'b0;
        ready_hold = 0;
        mismatch_count = 0;
        target_lvl = TARGET_RST;
        gain_lim   = GAIN_LIM_RST;
        attack     = ATTACK_RST;
        decay      = DECAY_RST;
        noise_thr  = NOISE_THR_RST;
        gain_state = UNITY_GAIN;

        directed_rows = '{
            // reset settings: unity gain, limit at unity
            '{ROW_WORD,  '0,            0,      1'b1, 0,      2048},
            '{ROW_WORD,  '0,            32767,  1'b1, 32767,  2048},
            '{ROW_WORD,  '0,            -32768, 1'b1, -32768, 2048},
            '{ROW_WORD,  '0,            655,    1'b1, 655,    2048},
            '{ROW_WORD,  '0,            -1,     1'b1, -1,     2048},
            // open the limit and let the gain rise and fall
            '{ROW_WRITE, REG_GAIN_LIM,  32767,  1'b0, 0, 0},
            '{ROW_WRITE, REG_TARGET,    8192,   1'b0, 0, 0},
            '{ROW_WORD,  '0,            1000,   1'b0, 0, 0},
            '{ROW_WORD,  '0,            32767,  1'b0, 0, 0},
            '{ROW_WORD,  '0,            -32768, 1'b0, 0, 0},
            // largest attack and decay
            '{ROW_WRITE, REG_ATTACK,    32767,  1'b0, 0, 0},
            '{ROW_WRITE, REG_DECAY,     32767,  1'b0, 0, 0},
            '{ROW_WORD,  '0,            656,    1'b0, 0, 0},
            '{ROW_WORD,  '0,            -656,   1'b0, 0, 0},
            '{ROW_WORD,  '0,            20000,  1'b0, 0, 0},
            // gate fully closed: no input can exceed it
            '{ROW_WRITE, REG_NOISE_THR, 32767,  1'b0, 0, 0},
            '{ROW_WORD,  '0,            32767,  1'b0, 0, 0},
            '{ROW_WORD,  '0,            -32768, 1'b0, 0, 0},
            // gate fully open
            '{ROW_WRITE, REG_NOISE_THR, 0,      1'b0, 0, 0},
            '{ROW_WORD,  '0,            0,      1'b0, 0, 0},
            '{ROW_WORD,  '0,            1,      1'b0, 0, 0},
            // zero target: error is minus the output level
            '{ROW_WRITE, REG_TARGET,    0,      1'b0, 0, 0},
            '{ROW_WORD,  '0,            5000,   1'b0, 0, 0},
            // limit below unity overrides the lower clamp
            '{ROW_WRITE, REG_GAIN_LIM,  1000,   1'b0, 0, 0},
            '{ROW_WORD,  '0,            3000,   1'b0, 0, 0},
            '{ROW_WORD,  '0,            3000,   1'b0, 0, 0},
            // zero limit: gain collapses and the output goes silent
            '{ROW_WRITE, REG_GAIN_LIM,  0,      1'b0, 0, 0},
            '{ROW_WORD,  '0,            12345,  1'b0, 0, 0},
            '{ROW_WORD,  '0,            -32768, 1'b1, 0,      0},
            // writes past the last register are dropped
            '{ROW_WRITE, REG_SPARE_LO,  1,      1'b0, 0, 0},
            '{ROW_WRITE, REG_SPARE_HI,  32767,  1'b0, 0, 0},
            // new settings apply at once: the next word uses the old gain, clamped to the new limits
            '{ROW_WRITE, REG_GAIN_LIM,  32767,  1'b0, 0, 0},
            '{ROW_WRITE, REG_TARGET,    32767,  1'b0, 0, 0},
            '{ROW_WRITE, REG_ATTACK,    0,      1'b0, 0, 0},
            '{ROW_WRITE, REG_DECAY,     0,      1'b0, 0, 0},
            '{ROW_WORD,  '0,            30000,  1'b1, 0,      2048},
            '{ROW_WORD,  '0,            30000,  1'b0, 0, 0},
            '{ROW_WORD,  '0,            -30000, 1'b0, 0, 0},
            '{ROW_WORD,  '0,            1,      1'b0, 0, 0},
            '{ROW_WORD,  '0,            -2,     1'b0, 0, 0}
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(directed_rows[i].addr, 15'(directed_rows[i].value));
            end
            else
                send_word(16'(directed_rows[i].value), directed_rows[i].has_exp,
                          directed_rows[i].exp_smp, directed_rows[i].exp_gain);
        end

        // random phases, each with fresh register settings
        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_idle();
            steady = (p % 4 == 1);
            write_reg(REG_TARGET, random_reg(32767));
            if ($urandom_range(0, 9) == 0)
                write_reg(REG_GAIN_LIM, 15'($urandom_range(0, 2047)));
            else
                write_reg(REG_GAIN_LIM, random_reg(16384) | 15'd2048);
            write_reg(REG_ATTACK, random_reg(4000));
            write_reg(REG_DECAY, random_reg(4000));
            write_reg(REG_NOISE_THR, random_reg(4000));
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                          15'($urandom));
            for (int k = 0; k < PHASE_LEN; k++)
            begin
                // a burst without idling now and then
                if (!steady && k == PHASE_LEN / 2)
                    steady = 1'b1;
                else if (k == PHASE_LEN / 2 + 12 && p % 4 != 1)
                    steady = 1'b0;
                send_word(random_sample(), 1'b0, 0, 0);
            end
        end

        steady = 1'b0;
        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_words.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
